// ===== rtl/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg
// shared types and constants of the clipped line rasterizer
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int MAX_DIM        = 4096;
  localparam int COORD_BITS_DEF = 16;
  localparam int REG_W          = 13;
  localparam int PIX_W          = 12;
  localparam int IDX_W          = 24;
  localparam int COL_W          = 24;
  localparam int BLEND_W        = 8;
  localparam int ERR_W          = 14;
  // clip arithmetic width: saturation at 2^29 needs 31 bits signed
  localparam int CW             = 32;
  localparam logic signed [CW-1:0] CLIP_LIMIT = 32'sd536870912;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture start item, run reject test
    logic clip_go;   // launch a clip division
    logic clip_sel;  // 0 start point, 1 end point
    logic finish;    // final recheck and bresenham setup
    logic step;      // emit a pixel
    logic idle_out;  // emit a no-pixel result
  } clr_cmd_t;

  typedef struct packed {
    logic reject;     // trivial reject after load
    logic edge_need;  // current edge stage needs a division
    logic div_done;
    logic active;
    logic last_rej;   // recheck failed
  } clr_sts_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
    if (v > CLIP_LIMIT) return CLIP_LIMIT;
    if (v < -CLIP_LIMIT) return -CLIP_LIMIT;
    return v[CW-1:0];
  endfunction

endpackage

// ===== rtl/clr_div.sv =====
// ----------------------------------------------------------------------------
// clr_div
// signed multiply then truncating restoring division, one quotient bit a cycle
// ----------------------------------------------------------------------------
module clr_div import clr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  logic signed [CW-1:0] c,
  output logic                 done,
  output logic signed [2*CW-1:0] q
);
  localparam int NW = 2 * CW;
  localparam int CNT_W = $clog2(NW + 2);

  logic [NW-1:0]    num;
  logic [NW-1:0]    quo;
  logic [NW:0]      rem;
  logic [CW-1:0]    den;
  logic             neg;
  logic             zero;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             mul_ph;
  logic signed [CW-1:0] ra, rb;
  logic signed [NW-1:0] prod;
  logic [NW:0]      trial;

  assign prod  = NW'(ra) * NW'(rb);
  assign trial = {rem[NW-1:0], num[NW-1]} - {{(NW-CW+1){1'b0}}, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      mul_ph <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        ra <= a;
        rb <= b;
        den <= c[CW-1] ? CW'(-c) : c;
        zero <= (c == '0);
        neg <= c[CW-1];
        mul_ph <= 1'b1;
      end else if (mul_ph) begin
        mul_ph <= 1'b0;
        busy <= 1'b1;
        cnt <= CNT_W'(NW);
        neg <= neg ^ prod[NW-1];
        num <= prod[NW-1] ? NW'(-prod) : prod;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        if (!trial[NW]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[NW-1:0], num[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
        num <= {num[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero) q = '0;
    else q = neg ? -$signed(quo) : $signed(quo);
  end
endmodule

// ===== rtl/clr_datapath.sv =====
// ----------------------------------------------------------------------------
// clr_datapath
// endpoint clipping registers, bresenham stepper and result register
// ----------------------------------------------------------------------------
module clr_datapath import clr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  clr_cmd_t              cmd,
  input  logic [1:0]            edge_no,
  output clr_sts_t              sts,
  input  logic [REG_W-1:0]      screen_width,
  input  logic [REG_W-1:0]      screen_height,
  input  logic signed [COORD_BITS-1:0] in_sx,
  input  logic signed [COORD_BITS-1:0] in_sy,
  input  logic signed [COORD_BITS-1:0] in_ex,
  input  logic signed [COORD_BITS-1:0] in_ey,
  input  logic [31:0]           in_colour,
  input  logic [BLEND_W-1:0]    in_blend,
  output logic                  o_drawn,
  output logic [PIX_W-1:0]      o_x,
  output logic [PIX_W-1:0]      o_y,
  output logic [IDX_W-1:0]      o_index,
  output logic [COL_W-1:0]      o_colour,
  output logic [BLEND_W-1:0]    o_blend,
  output logic                  o_last
);
  localparam logic signed [CW-1:0] MAXD = CW'(MAX_DIM);

  logic signed [CW-1:0] w, h;
  logic signed [CW-1:0] sx, sy, ex, ey, dx, dy;
  logic signed [CW-1:0] px, py;
  logic signed [CW-1:0] da, db, dc;
  logic signed [2*CW-1:0] q;
  logic div_done;
  logic edge_need;
  logic line_active, x_major, step_left_x, step_up_y;
  logic [PIX_W-1:0] cur_col, cur_row, stop_col, stop_row, span_x, span_y;
  logic signed [ERR_W-1:0] error_term;
  logic [COL_W-1:0] held_colour;
  logic [BLEND_W-1:0] held_blend;

  assign w = (CW'(screen_width) > MAXD) ? MAXD : CW'(screen_width);
  assign h = (CW'(screen_height) > MAXD) ? MAXD : CW'(screen_height);

  function automatic logic signed [CW-1:0] sext(input logic signed [COORD_BITS-1:0] v);
    return sat((CW+2)'(v));
  endfunction

  assign px = cmd.clip_sel ? ex : sx;
  assign py = cmd.clip_sel ? ey : sy;

  // division operands for the current edge
  always_comb begin
    case (edge_no)
      2'd0: begin da = px; db = dy; dc = dx; edge_need = px < 0; end
      2'd1: begin da = py; db = dx; dc = dy; edge_need = py < 0; end
      2'd2: begin da = px - w; db = dy; dc = dx; edge_need = px >= w; end
      default: begin da = py - h; db = dx; dc = dy; edge_need = py >= h; end
    endcase
  end

  clr_div u_div (
    .clk(clk), .rst(rst), .go(cmd.clip_go), .a(da), .b(db), .c(dc),
    .done(div_done), .q(q)
  );

  logic signed [CW+1:0] qs, upd;
  assign qs = (q > 2*CW'(CLIP_LIMIT)) ? (CW+2)'(2*CLIP_LIMIT) :
              (q < -2*CW'(CLIP_LIMIT)) ? -(CW+2)'(2*CLIP_LIMIT) : (CW+2)'(q);
  assign upd = (edge_no[0] ? (CW+2)'(px) : (CW+2)'(py)) - qs;

  assign sts.edge_need = edge_need;
  assign sts.div_done = div_done;
  assign sts.active   = line_active;
  assign sts.reject = (sx < 0 && ex < 0) || (sy < 0 && ey < 0) ||
                      (sx >= w && ex >= w) || (sy >= h && ey >= h);
  assign sts.last_rej = sx < 0 || ex < 0 || sy < 0 || ey < 0 ||
                        sx >= w || ex >= w || sy >= h || ey >= h;

  logic signed [CW-1:0] fdx, fdy, fax, fay;
  assign fdx = ex - sx;
  assign fdy = ey - sy;
  assign fax = fdx < 0 ? -fdx : fdx;
  assign fay = fdy < 0 ? -fdy : fdy;

  logic at_end;
  assign at_end = x_major ? (cur_col == stop_col) : (cur_row == stop_row);
  logic signed [ERR_W-1:0] e1;
  assign e1 = error_term - (x_major ? ERR_W'(span_y) : ERR_W'(span_x));

  logic [2*PIX_W:0] idx_mul;
  logic [PIX_W-1:0] pxo, pyo;
  assign pxo = at_end ? stop_col : cur_col;
  assign pyo = at_end ? stop_row : cur_row;
  assign idx_mul = pyo * w[PIX_W:0] + {(PIX_W+1)'(0), pxo};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      o_drawn <= 1'b0;
      o_last <= 1'b0;
    end else begin
      if (cmd.load) begin
        sx <= sext(in_sx); sy <= sext(in_sy);
        ex <= sext(in_ex); ey <= sext(in_ey);
        dx <= sext(in_ex) - sext(in_sx);
        dy <= sext(in_ey) - sext(in_sy);
        held_colour <= in_colour[COL_W-1:0];
        held_blend <= in_blend;
        line_active <= 1'b0;
      end
      if (div_done) begin
        if (cmd.clip_sel) begin
          if (edge_no[0]) begin ex <= sat(upd); ey <= 0; end
          else begin ey <= sat(upd); ex <= 0; end
          if (edge_no == 2'd2) ex <= w - 1;
          if (edge_no == 2'd3) ey <= h - 1;
        end else begin
          if (edge_no[0]) begin sx <= sat(upd); sy <= 0; end
          else begin sy <= sat(upd); sx <= 0; end
          if (edge_no == 2'd2) sx <= w - 1;
          if (edge_no == 2'd3) sy <= h - 1;
        end
      end
      if (cmd.finish) begin
        o_drawn <= 1'b0; o_x <= '0; o_y <= '0; o_index <= '0;
        o_colour <= '0; o_blend <= '0;
        o_last <= sts.last_rej;
        if (!sts.last_rej) begin
          line_active <= 1'b1;
          x_major <= fax > fay;
          span_x <= fax[PIX_W-1:0];
          span_y <= fay[PIX_W-1:0];
          error_term <= (fax > fay) ? ERR_W'(fax[PIX_W-1:1]) : ERR_W'(fay[PIX_W-1:1]);
          step_left_x <= fdx < 0;
          step_up_y <= fdy < 0;
          cur_col <= sx[PIX_W-1:0]; cur_row <= sy[PIX_W-1:0];
          stop_col <= ex[PIX_W-1:0]; stop_row <= ey[PIX_W-1:0];
        end
      end
      if (cmd.idle_out) begin
        o_drawn <= 1'b0; o_x <= '0; o_y <= '0; o_index <= '0;
        o_colour <= '0; o_blend <= '0; o_last <= 1'b1;
      end
      if (cmd.step) begin
        o_drawn <= 1'b1; o_x <= pxo; o_y <= pyo;
        o_index <= idx_mul[IDX_W-1:0];
        o_colour <= held_colour; o_blend <= held_blend; o_last <= at_end;
        if (at_end) line_active <= 1'b0;
        else if (x_major) begin
          cur_col <= step_left_x ? cur_col - 1'b1 : cur_col + 1'b1;
          if (e1 <= 0) begin
            cur_row <= step_up_y ? cur_row - 1'b1 : cur_row + 1'b1;
            error_term <= e1 + ERR_W'(span_x);
          end else error_term <= e1;
        end else begin
          cur_row <= step_up_y ? cur_row - 1'b1 : cur_row + 1'b1;
          if (e1 <= 0) begin
            cur_col <= step_left_x ? cur_col - 1'b1 : cur_col + 1'b1;
            error_term <= e1 + ERR_W'(span_y);
          end else error_term <= e1;
        end
      end
    end
  end
endmodule

// ===== rtl/clr_ctrl.sv =====
// ----------------------------------------------------------------------------
// clr_ctrl
// sequencer: handshake, reject, eight clip stages, pixel steps
// ----------------------------------------------------------------------------
module clr_ctrl import clr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  clr_sts_t   sts,
  output clr_cmd_t   cmd,
  output logic [1:0] edge_no
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_EDGE  = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic sel;
  logic [1:0] edge_r;
  logic take;

  assign edge_no = edge_r;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.clip_sel = sel;
    state_next = state;
    unique case (state)
      S_IDLE: if (take) begin
        if (in_action == ACT_START) begin
          cmd.load = 1'b1; state_next = S_CHECK;
        end else if (sts.active) cmd.step = 1'b1;
        else cmd.idle_out = 1'b1;
      end
      S_CHECK: state_next = sts.reject ? S_FIN : S_EDGE;
      S_EDGE: if (sts.edge_need) begin
        cmd.clip_go = 1'b1; state_next = S_DIV;
      end else if (sel && edge_r == 2'd3) state_next = S_FIN;
      S_DIV: if (sts.div_done) begin
        state_next = (sel && edge_r == 2'd3) ? S_FIN : S_EDGE;
      end
      S_FIN: begin cmd.finish = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; sel <= 1'b0; edge_r <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.step || cmd.idle_out || cmd.finish) out_valid <= 1'b1;
      if (state == S_CHECK) begin sel <= 1'b0; edge_r <= '0; end
      if ((state == S_EDGE && !sts.edge_need) || (state == S_DIV && sts.div_done)) begin
        edge_r <= edge_r + 1'b1;
        if (edge_r == 2'd3) sel <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.step, cmd.idle_out, cmd.finish}) <= 1)
    else $error("conflicting commands");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finish lost result");
`endif
endmodule

// ===== rtl/clipped_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// clips a line to the screen and streams its bresenham pixels
// ----------------------------------------------------------------------------
// s_axis carries one command per transaction: action 0 starts a line,
// action 1 asks for the next pixel. Every command yields exactly one
// transaction on m_axis. A step command gives its pixel in the cycle
// after acceptance, and a new step is taken every cycle while m_axis
// drains. A start command runs the reject test and, unless it rejects,
// eight clip edge stages (one per edge per endpoint); a stage that needs
// a division launches it, multiplies, runs the shared restoring divider
// and then stores the clipped endpoint. The result register holds while
// m_axis_tready is low; a new command is taken only when it is free or
// draining. cfg writes set screen width (index 0) and height (index 1)
// and must be issued while idle. Reset clears the line and restores 320
// by 240.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer import clr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, pen_colour, blend_code
  input  logic [4*COORD_BITS+39:0] s_axis_tdata,
  // action
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y, pixel_index, out_colour, out_blend
  output logic [79:0] m_axis_tdata,
  // drawn
  output logic m_axis_tuser,
  output logic m_axis_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [REG_W-1:0] cfg_data
);
  logic [REG_W-1:0] screen_width, screen_height;
  clr_cmd_t cmd;
  clr_sts_t sts;
  logic [1:0] edge_no;
  logic o_drawn;
  logic [PIX_W-1:0] o_x, o_y;
  logic [IDX_W-1:0] o_index;
  logic [COL_W-1:0] o_colour;
  logic [BLEND_W-1:0] o_blend;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= REG_W'(320); screen_height <= REG_W'(240);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) screen_width <= cfg_data;
      else screen_height <= cfg_data;
    end
  end

  clr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_action(s_axis_tuser),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .sts(sts), .cmd(cmd), .edge_no(edge_no)
  );

  clr_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .edge_no(edge_no), .sts(sts),
    .screen_width(screen_width), .screen_height(screen_height),
    .in_sx(s_axis_tdata[COORD_BITS-1:0]),
    .in_sy(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_ex(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .in_ey(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .in_colour(s_axis_tdata[4*COORD_BITS+31:4*COORD_BITS]),
    .in_blend(s_axis_tdata[4*COORD_BITS+39:4*COORD_BITS+32]),
    .o_drawn(o_drawn), .o_x(o_x), .o_y(o_y), .o_index(o_index),
    .o_colour(o_colour), .o_blend(o_blend), .o_last(m_axis_tlast)
  );

  assign m_axis_tdata = {o_blend, o_colour, o_index, o_y, o_x};
  assign m_axis_tuser = o_drawn;
endmodule
